### sv/rfc_pkg.sv
// Shared types, constants and CRC helper for the RTU frame CRC checker.
package rfc_pkg;

    localparam int unsigned MAX_FRAME    = 256;
    localparam int unsigned COUNT_W      = 9;
    localparam int unsigned MIN_FRAME    = 4;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [15:0] GAP_RESET    = 16'd750;
    localparam logic [15:0] SILENCE_MAX  = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CRC_ERROR = 2'd1,
        ST_TOO_SHORT = 2'd2,
        ST_TOO_LONG  = 2'd3
    } t_status;

    typedef enum logic {
        ACT_BYTE = 1'b0,
        ACT_TICK = 1'b1
    } t_action;

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   frame_length;
        logic [15:0]          received_crc;
        logic [15:0]          computed_crc;
    } t_result;

    // One entry of the reflected 0xA001 byte table.
    function automatic logic [15:0] crc_table(input logic [7:0] idx);
        logic [15:0] c;
        c = {8'h00, idx};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) c = (c >> 1) ^ CRC_POLY;
            else      c = c >> 1;
        end
        return c;
    endfunction

endpackage

### sv/rfc_crc_step.sv
// Byte-wide table update of the Modbus CRC-16.
module rfc_crc_step
    import rfc_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    assign o_crc = {8'h00, i_crc[15:8]} ^ crc_table(i_crc[7:0] ^ i_byte);

endmodule

### sv/rfc_frame_core.sv
// Input register and frame state: byte count, tail bytes, CRC and silence timer.
module rfc_frame_core
    import rfc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_action,
    input  logic [7:0]    i_data_byte,
    input  logic [15:0]   i_char_gap,
    input  logic          i_slot_free,
    output logic          o_res_valid,
    output t_result       o_res
);

    logic               r_in_valid;
    logic               r_action;
    logic [7:0]         r_byte;

    logic [15:0]        r_crc,     n_crc;
    logic [7:0]         r_tail0,   n_tail0;
    logic [7:0]         r_tail1,   n_tail1;
    logic [COUNT_W-1:0] r_count,   n_count;
    logic               r_ovf,     n_ovf;
    logic [15:0]        r_silence, n_silence;

    logic [15:0]        crc_next;
    logic [15:0]        sil_inc;
    logic [15:0]        rx_crc;
    logic [15:0]        cc_crc;
    logic               res_hit;
    logic               advance;

    rfc_crc_step u_crc (
        .i_crc  (r_crc),
        .i_byte (r_tail0),
        .o_crc  (crc_next)
    );

    assign sil_inc = (r_silence != SILENCE_MAX) ? r_silence + 16'd1 : r_silence;
    assign rx_crc  = {r_tail0, r_tail1};
    // Modbus sends the low CRC byte first
    assign cc_crc  = {r_crc[7:0], r_crc[15:8]};
    assign res_hit = r_in_valid && (r_action == ACT_TICK) && (r_count != '0)
                     && (sil_inc >= i_char_gap);

    assign advance     = !res_hit || i_slot_free;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_res_valid = res_hit;

    always_comb begin
        o_res.frame_length = r_count;
        o_res.received_crc = rx_crc;
        o_res.computed_crc = cc_crc;
        if (r_ovf) begin
            o_res.status = ST_TOO_LONG;
        end else if (r_count < COUNT_W'(MIN_FRAME)) begin
            o_res.status       = ST_TOO_SHORT;
            o_res.received_crc = '0;
            o_res.computed_crc = '0;
        end else if (rx_crc == cc_crc) begin
            o_res.status = ST_OK;
        end else begin
            o_res.status = ST_CRC_ERROR;
        end
    end

    always_comb begin
        n_crc     = r_crc;
        n_tail0   = r_tail0;
        n_tail1   = r_tail1;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_silence = r_silence;
        if (r_in_valid && advance) begin
            if (r_action == ACT_BYTE) begin
                if (r_count >= COUNT_W'(2)) n_crc = crc_next;
                n_tail0 = r_tail1;
                n_tail1 = r_byte;
                if (r_count < COUNT_W'(MAX_FRAME)) n_count = r_count + COUNT_W'(1);
                else                               n_ovf   = 1'b1;
                n_silence = '0;
            end else if (r_count != '0) begin
                if (res_hit) begin
                    n_crc     = CRC_INIT;
                    n_tail0   = '0;
                    n_tail1   = '0;
                    n_count   = '0;
                    n_ovf     = 1'b0;
                    n_silence = '0;
                end else begin
                    n_silence = sil_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_crc      <= CRC_INIT;
            r_tail0    <= '0;
            r_tail1    <= '0;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_silence  <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            r_crc     <= n_crc;
            r_tail0   <= n_tail0;
            r_tail1   <= n_tail1;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_silence <= n_silence;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_action <= i_action;
            r_byte   <= i_data_byte;
        end
    end

endmodule

### sv/rfc_out_reg.sv
// Result register holding one finished frame report until it is taken.
module rfc_out_reg
    import rfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_slot_free,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_slot_free = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_slot_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_slot_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

### sv/rtu_frame_crc_checker.sv
// Top level of the Modbus RTU frame end detector and CRC-16 checker.
// Each item is a received byte or a time tick; one item is taken every cycle unless
// the input stalls, and its effect on the frame state is worked out in a single pass
// between the input register and the result register, which registers the report of
// the tick that ends a frame. A frame ends when char_gap ticks follow its last byte
// with no byte between; its report gives the status, the byte count (saturated at 256)
// and the received and computed CRC in wire order. Input stalls only while a finished
// report waits in the result register and another one is ready behind it. char_gap may
// be written at any time the block is idle; the configuration port is always ready.
module rtu_frame_crc_checker
    import rfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [8:0]  o_frame_length,
    output logic [15:0] o_received_crc,
    output logic [15:0] o_computed_crc,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_char_gap;
    logic        res_valid;
    logic        slot_free;
    t_result     res;
    t_result     out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_gap <= GAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_char_gap <= i_cfg_data;
        end
    end

    rfc_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .i_char_gap  (r_char_gap),
        .i_slot_free (slot_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rfc_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_slot_free (slot_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (out_res)
    );

    assign o_status       = out_res.status;
    assign o_frame_length = out_res.frame_length;
    assign o_received_crc = out_res.received_crc;
    assign o_computed_crc = out_res.computed_crc;

endmodule

### verif/rtu_frame_crc_checker_tb.sv
// Self-checking testbench for the RTU frame CRC checker: directed and random byte/tick items.
module rtu_frame_crc_checker_tb;
    import rfc_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS     = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        in_action = ACT_BYTE;
    logic [7:0]  in_data = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  out_status;
    logic [8:0]  out_frame_length;
    logic [15:0] out_received_crc;
    logic [15:0] out_computed_crc;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'h0000;

    // frame tracker state
    logic [15:0] gap_cfg;
    logic [15:0] crc_run;
    logic [7:0]  tail_old;
    logic [7:0]  tail_new;
    logic [8:0]  frame_bytes;
    logic        frame_overrun;
    logic [15:0] quiet_ticks;

    t_result     pending_reports [$];
    logic [7:0]  frame_buf [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_left = 0;
    int unsigned items_sent = 0;
    int unsigned reports_seen = 0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;

    rtu_frame_crc_checker uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_action       (in_action),
        .i_data_byte    (in_data),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (out_status),
        .o_frame_length (out_frame_length),
        .o_received_crc (out_received_crc),
        .o_computed_crc (out_computed_crc),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void clear_frame_state();
        crc_run       = CRC_INIT;
        tail_old      = 8'h00;
        tail_new      = 8'h00;
        frame_bytes   = '0;
        frame_overrun = 1'b0;
        quiet_ticks   = 16'h0000;
    endfunction

    // Advance the frame tracker by one accepted item; queue a report when a frame ends.
    function automatic void track_frame_item(input t_action act, input logic [7:0] b);
        t_result r;
        if (act == ACT_BYTE) begin
            if (frame_bytes >= 2) crc_run = modbus_crc_byte(crc_run, tail_old);
            tail_old = tail_new;
            tail_new = b;
            if (frame_bytes < MAX_FRAME) frame_bytes = frame_bytes + 1'b1;
            else frame_overrun = 1'b1;
            quiet_ticks = 16'h0000;
            return;
        end
        if (frame_bytes == 0) return;
        if (quiet_ticks != SILENCE_MAX) quiet_ticks = quiet_ticks + 1'b1;
        // a gap of zero behaves as one: quiet_ticks is at least 1 here
        if (quiet_ticks < gap_cfg) return;
        r.frame_length = frame_bytes;
        r.received_crc = {tail_old, tail_new};
        r.computed_crc = {crc_run[7:0], crc_run[15:8]};
        if (frame_overrun) begin
            r.status = ST_TOO_LONG;
        end else if (frame_bytes < MIN_FRAME) begin
            r.status       = ST_TOO_SHORT;
            r.received_crc = 16'h0000;
            r.computed_crc = 16'h0000;
        end else if (r.received_crc == r.computed_crc) begin
            r.status = ST_OK;
        end else begin
            r.status = ST_CRC_ERROR;
        end
        pending_reports.push_back(r);
        clear_frame_state();
    endfunction

    task automatic send_item(input t_action act, input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_data   <= b;
        do @(posedge clk); while (in_stall);
        items_sent++;
        track_frame_item(act, b);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_gap(input logic [15:0] g);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        do @(posedge clk); while (!cfg_ready);
        gap_cfg = g;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_frame(input int n, input bit randomise, input logic [7:0] pattern);
        frame_buf.delete();
        repeat (n) frame_buf.push_back(randomise ? 8'($urandom) : pattern);
    endtask

    // Send frame_buf, optionally followed by its CRC (low byte first) with some bits flipped.
    task automatic send_frame(input bit with_crc, input logic [15:0] flip);
        logic [15:0] c;
        if (with_crc) begin
            c = CRC_INIT;
            foreach (frame_buf[k]) c = modbus_crc_byte(c, frame_buf[k]);
            frame_buf.push_back(c[7:0] ^ flip[7:0]);
            frame_buf.push_back(c[15:8] ^ flip[15:8]);
        end
        foreach (frame_buf[k]) send_item(ACT_BYTE, frame_buf[k]);
    endtask

    task automatic flush_frame();
        while (frame_bytes != 0) send_item(ACT_TICK, 8'($urandom));
    endtask

    task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic test_default_gap();
        repeat (3) send_item(ACT_TICK, 8'($urandom));
        fill_frame(2, 1'b1, 8'h00);
        send_frame(1'b1, 16'h0000);
        flush_frame();
    endtask

    task automatic test_short_frames();
        wait_drained();
        write_gap(16'd3);
        fill_frame(1, 1'b0, 8'h00);
        send_frame(1'b0, 16'h0000);
        flush_frame();
        fill_frame(2, 1'b0, 8'hFF);
        send_frame(1'b0, 16'h0000);
        flush_frame();
        fill_frame(3, 1'b1, 8'h00);
        send_frame(1'b0, 16'h0000);
        flush_frame();
    endtask

    task automatic test_crc_check();
        fill_frame(2, 1'b1, 8'h00);
        send_frame(1'b1, 16'h0000);
        flush_frame();
        fill_frame(6, 1'b0, 8'h00);
        send_frame(1'b1, 16'h0000);
        flush_frame();
        fill_frame(6, 1'b0, 8'hFF);
        send_frame(1'b1, 16'h0000);
        flush_frame();
        fill_frame(4, 1'b1, 8'h00);
        send_frame(1'b1, 16'h8000);
        flush_frame();
        fill_frame(4, 1'b0, 8'hFF);
        send_frame(1'b0, 16'h0000);
        flush_frame();
    endtask

    // A byte inside the silence restarts the count; the frame carries on.
    task automatic test_silence_restart();
        fill_frame(5, 1'b1, 8'h00);
        send_frame(1'b0, 16'h0000);
        repeat (2) send_item(ACT_TICK, 8'($urandom));
        send_item(ACT_BYTE, 8'($urandom));
        repeat (2) send_item(ACT_TICK, 8'($urandom));
        send_item(ACT_BYTE, 8'($urandom));
        flush_frame();
    endtask

    task automatic test_long_frames();
        wait_drained();
        write_gap(16'd2);
        fill_frame(MAX_FRAME - 2, 1'b1, 8'h00);
        send_frame(1'b1, 16'h0000);
        flush_frame();
        fill_frame(MAX_FRAME - 1, 1'b1, 8'h00);
        send_frame(1'b1, 16'h0000);
        flush_frame();
    endtask

    task automatic test_gap_extremes();
        wait_drained();
        write_gap(16'd0);
        fill_frame(2, 1'b1, 8'h00);
        send_frame(1'b1, 16'h0000);
        send_item(ACT_TICK, 8'($urandom));
        repeat (2) send_item(ACT_TICK, 8'($urandom));
        wait_drained();
        write_gap(16'd1);
        fill_frame(2, 1'b1, 8'h00);
        send_frame(1'b0, 16'h0000);
        send_item(ACT_TICK, 8'($urandom));
        wait_drained();
        // widest gap: a few ticks must not end the frame; a short gap then does
        write_gap(16'hFFFF);
        fill_frame(3, 1'b1, 8'h00);
        send_frame(1'b1, 16'h0000);
        repeat (5) send_item(ACT_TICK, 8'($urandom));
        wait_drained();
        write_gap(16'd1);
        flush_frame();
    endtask

    // Receiver holds off while short frames keep coming, so the block backs up.
    task automatic test_backpressure();
        wait_drained();
        write_gap(16'd1);
        hold_left = HOLD_OFF_CYCLES;
        repeat (20) begin
            fill_frame($urandom_range(4, 2), 1'b1, 8'h00);
            send_frame(1'b1, 16'h0000);
            flush_frame();
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned first_item;
        int unsigned pick;
        wait_drained();
        write_gap(16'($urandom_range(8, 1)));
        first_item = items_sent;
        while (items_sent - first_item < n_items) begin
            pick = $urandom_range(199, 0);
            if (pick < 2) begin
                fill_frame($urandom_range(298, 250), 1'b1, 8'h00);
                send_frame(1'b1, ($urandom_range(1, 0) != 0) ? 16'h0000 : 16'h0004);
            end else if (pick < 26) begin
                fill_frame($urandom_range(3, 1), 1'b1, 8'h00);
                send_frame(1'b0, 16'h0000);
            end else begin
                fill_frame($urandom_range(14, 2), 1'b1, 8'h00);
                send_frame(1'b1, ($urandom_range(99, 0) < 75) ? 16'h0000 :
                                 (16'h0001 << $urandom_range(15, 0)));
            end
            pick = $urandom_range(99, 0);
            if (pick < 10) begin
                // broken silence: the next frame's bytes run on into this one
                if (gap_cfg > 1)
                    repeat ($urandom_range(gap_cfg - 1, 1)) send_item(ACT_TICK, 8'($urandom));
            end else if (pick < 16) begin
                repeat ($urandom_range(6, 1))
                    send_item(t_action'($urandom_range(1, 0)), 8'($urandom));
            end else begin
                flush_frame();
                if (pick > 80) repeat ($urandom_range(3, 1)) send_item(ACT_TICK, 8'($urandom));
            end
            if ($urandom_range(99, 0) < 2) wait_drained();
        end
        flush_frame();
    endtask

    // receiver side: random stalls, or a counted hold-off
    always @(negedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin : report_check
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                $error("unexpected report: status %0d length %0d", out_status, out_frame_length);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                if (want.status !== out_status) begin
                    $error("status: expected %0d, got %0d", want.status, out_status);
                    errors++;
                end
                if (want.frame_length !== out_frame_length) begin
                    $error("frame_length: expected %0d, got %0d",
                           want.frame_length, out_frame_length);
                    errors++;
                end
                if (want.received_crc !== out_received_crc) begin
                    $error("received_crc: expected %04h, got %04h",
                           want.received_crc, out_received_crc);
                    errors++;
                end
                if (want.computed_crc !== out_computed_crc) begin
                    $error("computed_crc: expected %04h, got %04h",
                           want.computed_crc, out_computed_crc);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports pending",
                     cycle_count, pending_reports.size());
            $display("rtu_frame_crc_checker regression: fail");
            $finish;
        end
    end

    initial begin
        gap_cfg = GAP_RESET;
        clear_frame_state();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idle(10, 65);
        test_default_gap();
        test_short_frames();
        test_crc_check();
        test_silence_restart();
        test_long_frames();
        test_gap_extremes();
        test_random_traffic(PHASE_ITEMS);

        set_idle(65, 10);
        test_backpressure();
        test_random_traffic(PHASE_ITEMS);

        set_idle(0, 0);
        test_random_traffic(PHASE_ITEMS);

        wait_drained();
        repeat (20) @(posedge clk);
        if (pending_reports.size() != 0) begin
            $error("%0d expected reports never arrived", pending_reports.size());
            errors++;
        end
        $display("covered %0d byte/tick items and %0d frame reports; gaps 0, 1, 2, 3, 750, 65535",
                 items_sent, reports_seen);
        $display("short, good, bad-CRC and overlong frames under mixed stalls and a %0d-cycle hold-off",
                 HOLD_OFF_CYCLES);
        if (errors == 0)
            $display("rtu_frame_crc_checker regression: pass");
        else
            $display("rtu_frame_crc_checker regression: fail");
        $finish;
    end

endmodule

### files.f
sv/rfc_pkg.sv
sv/rfc_crc_step.sv
sv/rfc_frame_core.sv
sv/rfc_out_reg.sv
sv/rtu_frame_crc_checker.sv
verif/rtu_frame_crc_checker_tb.sv
